>>> hw/rtl/mst_pkg.sv
`timescale 1ns / 1ps
// mst_pkg: shared types, character codes and helper functions for the
// macro syntax state tracker; no dependencies

package mst_pkg;

  localparam int DEPTH_BITS_DEF = 8;

  localparam int IN_TDATA_W  = 16;  // char_code, arg_count, zero fill
  localparam int OUT_TDATA_W = 8;   // syntax_state, error_code, zero fill

  localparam logic [7:0] CH_BSLASH  = 8'h5C;
  localparam logic [7:0] CH_HASH    = 8'h23;
  localparam logic [7:0] CH_PERCENT = 8'h25;
  localparam logic [7:0] CH_LBRACE  = 8'h7B;
  localparam logic [7:0] CH_RBRACE  = 8'h7D;
  localparam logic [7:0] CH_NL      = 8'h0A;
  localparam logic [7:0] CH_TAB     = 8'h09;
  localparam logic [7:0] CH_SPACE   = 8'h20;

  typedef enum logic [4:0] {
    ST_PLAIN   = 5'd0,
    ST_ESC     = 5'd1,
    ST_MACRO   = 5'd2,
    ST_COMMENT = 5'd3,
    ST_AFTER   = 5'd4,
    ST_A1B     = 5'd5,
    ST_A1      = 5'd6,
    ST_A1E     = 5'd7,
    ST_A1END   = 5'd8,
    ST_A2B     = 5'd9,
    ST_A2      = 5'd10,
    ST_A2E     = 5'd11,
    ST_A2END   = 5'd12,
    ST_A3B     = 5'd13,
    ST_A3      = 5'd14,
    ST_A3E     = 5'd15,
    ST_MEND    = 5'd16,
    ST_BADESC  = 5'd17
  } state_t;

  typedef enum logic [1:0] {
    ERR_NONE      = 2'd0,
    ERR_BAD_MACRO = 2'd1,
    ERR_NO_BRACE  = 2'd2,
    ERR_OVERFLOW  = 2'd3
  } err_t;

  // tracker registers other than the brace depth
  typedef struct packed {
    state_t parse;
    state_t saved;
    err_t   err;
  } track_t;

  localparam track_t TRACK_RESET = '{parse: ST_PLAIN, saved: ST_PLAIN, err: ERR_NONE};

  function automatic logic is_alnum(input logic [7:0] c);
    return (c inside {[8'h30:8'h39], [8'h41:8'h5A], [8'h61:8'h7A]});
  endfunction

  function automatic logic is_escapable(input logic [7:0] c);
    return (c inside {CH_BSLASH, CH_HASH, CH_PERCENT, CH_LBRACE, CH_RBRACE});
  endfunction

endpackage

>>> hw/rtl/mst_step.sv
`timescale 1ns / 1ps
// mst_step: combinational transition of the syntax tracker for one word
// depends on mst_pkg

module mst_step
  import mst_pkg::*;
#(
  parameter int DEPTH_BITS = DEPTH_BITS_DEF
) (
  input  logic [7:0]            char_code,
  input  logic [1:0]            arg_count,
  input  track_t                trk,
  input  logic [DEPTH_BITS-1:0] depth,
  output track_t                trk_next,
  output logic [DEPTH_BITS-1:0] depth_next
);

  localparam logic [DEPTH_BITS-1:0] DEPTH_MAX = '1;

  logic [1:0]            n;
  state_t                s;
  track_t                t;
  logic [DEPTH_BITS-1:0] d;
  logic [DEPTH_BITS-1:0] d_dec;
  logic                  skip;
  logic                  at_max;
  logic                  balanced;

  always_comb begin
    n        = (arg_count == 2'd0) ? 2'd1 : arg_count;
    t        = trk;
    d        = depth;
    s        = trk.parse;
    skip     = 1'b0;
    at_max   = (depth == DEPTH_MAX);
    d_dec    = (depth != '0) ? depth - 1'b1 : '0;
    balanced = (d_dec == '0);

    if (trk.err == ERR_NONE) begin
      // after a comment: skip blanks, then resume in the saved state
      if (trk.parse == ST_AFTER) begin
        if (char_code == CH_SPACE || char_code == CH_TAB) begin
          skip = 1'b1;
        end else begin
          s       = trk.saved;
          t.parse = trk.saved;
        end
      end

      if (!skip) begin
        if (char_code == CH_PERCENT &&
            !(s inside {ST_ESC, ST_A1E, ST_A2E, ST_A3E, ST_COMMENT})) begin
          t.saved = s;
          t.parse = ST_COMMENT;
        end else begin
          case (s)
            ST_PLAIN, ST_BADESC, ST_MEND: begin
              t.parse = (char_code == CH_BSLASH) ? ST_ESC : ST_PLAIN;
            end
            ST_ESC: begin
              if (is_alnum(char_code))          t.parse = ST_MACRO;
              else if (is_escapable(char_code)) t.parse = ST_PLAIN;
              else                              t.parse = ST_BADESC;
            end
            ST_COMMENT: begin
              if (char_code == CH_NL) t.parse = ST_AFTER;
            end
            ST_MACRO: begin
              if (char_code == CH_LBRACE) begin
                if (at_max) begin
                  t.err = ERR_OVERFLOW;
                end else begin
                  d       = depth + 1'b1;
                  t.parse = ST_A1B;
                end
              end else if (!is_alnum(char_code)) begin
                t.err = ERR_BAD_MACRO;
              end
            end
            ST_A1, ST_A2, ST_A3: begin
              if (char_code == CH_BSLASH) begin
                t.parse = state_t'(s + 5'd1);
              end else if (char_code == CH_LBRACE) begin
                if (at_max) t.err = ERR_OVERFLOW;
                else        d = depth + 1'b1;
              end else if (char_code == CH_RBRACE) begin
                d = d_dec;
                if (balanced) begin
                  if (n == 2'd1)      t.parse = ST_MEND;
                  else if (n == 2'd2) t.parse = (s == ST_A1) ? ST_A1END : ST_MEND;
                  else if (s == ST_A1) t.parse = ST_A1END;
                  else if (s == ST_A2) t.parse = ST_A2END;
                  else                 t.parse = ST_MEND;
                end
              end
            end
            ST_A1E, ST_A2E, ST_A3E: begin
              t.parse = state_t'(s - 5'd1);
            end
            ST_A1B, ST_A2B, ST_A3B: begin
              if (char_code == CH_BSLASH) begin
                t.parse = state_t'(s + 5'd2);
              end else if (char_code == CH_LBRACE) begin
                if (at_max) begin
                  t.err = ERR_OVERFLOW;
                end else begin
                  d       = depth + 1'b1;
                  t.parse = state_t'(s + 5'd1);
                end
              end else if (char_code == CH_RBRACE) begin
                d = d_dec;
                if (s == ST_A1B)      t.parse = (n == 2'd1) ? ST_MEND : ST_A1END;
                else if (s == ST_A2B) t.parse = (n == 2'd2) ? ST_MEND : ST_A2END;
                else                  t.parse = ST_MEND;
              end else begin
                t.parse = state_t'(s + 5'd1);
              end
            end
            ST_A1END, ST_A2END: begin
              if ((s == ST_A1END && n == 2'd1) || (s == ST_A2END && n == 2'd2)) begin
                t.parse = ST_MEND;
              end else if (char_code != CH_LBRACE) begin
                t.err = ERR_NO_BRACE;
              end else if (at_max) begin
                t.err = ERR_OVERFLOW;
              end else begin
                d       = depth + 1'b1;
                t.parse = state_t'(s + 5'd1);
              end
            end
            default: begin
              t.parse = ST_PLAIN;
            end
          endcase
        end
      end
    end

    trk_next   = t;
    depth_next = d;
  end

endmodule

>>> hw/rtl/macro_syntax_state_tracker.sv
`timescale 1ns / 1ps
// macro_syntax_state_tracker: top level, input register, tracker state,
// result register; depends on mst_pkg and mst_step
//
//   channel | dir | tdata fields (lsb first)                | notes
//   --------+-----+------------------------------------------+----------------
//   s_axis  | in  | char_code[7:0], arg_count[9:8], 0[15:10] | one char/word
//   m_axis  | out | syntax_state[4:0], error_code[6:5], 0[7] | one per input
//
// one word in, one word out; a taken word passes the input register, then
// the result register, before it shows on m_tdata
// sustained rate is one word per cycle while m_tready is high: the mst_step
// transition is the only logic between the input and result/state registers
// rst (synchronous, active high) clears the tracker to plain text, depth
// zero and no error, and empties both registers
// a stalled result holds the input register; s_tready stays high while
// the result register is empty or being taken
// once an error is latched, every later word returns the same state/code

module macro_syntax_state_tracker
  import mst_pkg::*;
#(
  parameter int DEPTH_BITS = DEPTH_BITS_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   s_tvalid,
  output logic                   s_tready,
  input  logic [IN_TDATA_W-1:0]  s_tdata,   // char_code[7:0], arg_count[9:8]
  output logic                   m_tvalid,
  input  logic                   m_tready,
  output logic [OUT_TDATA_W-1:0] m_tdata    // syntax_state[4:0], error_code[6:5]
);

  // input register
  logic       in_valid;
  logic [7:0] in_char;
  logic [1:0] in_count;

  // tracker state
  track_t                trk;
  track_t                trk_next;
  logic [DEPTH_BITS-1:0] depth;
  logic [DEPTH_BITS-1:0] depth_next;

  // result register
  logic   out_valid;
  state_t out_state;
  err_t   out_err;

  logic adv;

  // the held word moves on when the result slot is free or being emptied
  assign adv      = in_valid && (!out_valid || m_tready);
  assign s_tready = !in_valid || adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_char  <= s_tdata[7:0];
      in_count <= s_tdata[9:8];
    end
  end

  mst_step #(
    .DEPTH_BITS (DEPTH_BITS)
  ) u_step (
    .char_code  (in_char),
    .arg_count  (in_count),
    .trk        (trk),
    .depth      (depth),
    .trk_next   (trk_next),
    .depth_next (depth_next)
  );

  // tracker state and result advance together
  always_ff @(posedge clk) begin
    if (rst) begin
      trk       <= TRACK_RESET;
      depth     <= '0;
      out_valid <= 1'b0;
      out_state <= ST_PLAIN;
      out_err   <= ERR_NONE;
    end else if (adv) begin
      trk       <= trk_next;
      depth     <= depth_next;
      out_valid <= 1'b1;
      out_state <= trk_next.parse;
      out_err   <= trk_next.err;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = {1'b0, out_err, out_state};

endmodule

>>> hw/rtl/mst_checker.sv
`timescale 1ns / 1ps
// mst_checker: port-level assertions for macro_syntax_state_tracker,
// bound to the top level; depends on mst_pkg

module mst_checker
  import mst_pkg::*;
(
  input logic                   clk,
  input logic                   rst,
  input logic                   s_tvalid,
  input logic                   s_tready,
  input logic [IN_TDATA_W-1:0]  s_tdata,
  input logic                   m_tvalid,
  input logic                   m_tready,
  input logic [OUT_TDATA_W-1:0] m_tdata
);

  // nothing to show right after reset
  a_reset_empty: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("m_tvalid high after reset");

  // a held result stays put
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("result changed while stalled");

  // input only backs up behind a stalled result
  a_backpressure: assert property (@(posedge clk) disable iff (rst)
    !s_tready |-> m_tvalid && !m_tready)
    else $error("s_tready low without output stall");

  // a latched error never clears or changes
  a_err_sticky: assert property (@(posedge clk) disable iff (rst)
    m_tdata[6:5] != ERR_NONE |=> m_tdata[6:5] == $past(m_tdata[6:5]))
    else $error("error code changed after latching");

  // state code always a defined one
  a_state_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tdata[4:0] <= ST_BADESC)
    else $error("undefined syntax state on output");

endmodule

bind macro_syntax_state_tracker mst_checker u_mst_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .s_tdata  (s_tdata),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);

>>> verif/tb.sv
`timescale 1ns / 1ps
// tb: self-checking bench for macro_syntax_state_tracker; streams characters
// in, predicts every state/error word and compares; depends on mst_pkg and the rtl

module tb;
  import mst_pkg::*;

  localparam int DEPTH_W   = DEPTH_BITS_DEF;
  localparam int N_RANDOM  = 410;
  localparam int CALM_TAIL = 40;   // words at the end sent with no idling

  // tracker state as the bench sees it
  typedef struct packed {
    state_t               st;
    state_t               saved;
    logic [DEPTH_W-1:0]   depth;
    err_t                 err;
  } trk_t;

  // one character word waiting to be sent
  typedef struct packed {
    logic       hold;    // wait for all results before sending this one
    logic [1:0] nargs;
    logic [7:0] ch;
  } word_t;

  // one expected result word
  typedef struct packed {
    state_t st;
    err_t   err;
  } syntax_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic                   s_tvalid = 1'b0;
  logic                   s_tready;
  logic [IN_TDATA_W-1:0]  s_tdata = '0;   // char_code[7:0], arg_count[9:8]
  logic                   m_tvalid;
  logic                   m_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_tdata;        // syntax_state[4:0], error_code[6:5]

  macro_syntax_state_tracker dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  word_t   char_q[$];     // characters still to be sent
  syntax_t syntax_q[$];   // predicted results not yet seen
  trk_t    gen_trk;       // tracker state seen by the stimulus generator
  trk_t    tracker_now;   // tracker state at the last accepted character
  logic [1:0] gen_nargs = 2'd1;

  int n_acc = 0;          // characters taken by the block
  int n_got = 0;          // result words taken from the block
  int total_items = 1 << 30;
  int mismatches = 0;
  int deepest = 0;
  int tx_gap = 0;
  int rx_gap = 0;
  logic rx_long = 1'b0;
  logic long_done = 1'b0;

  // ---------------------------------------------------------------------
  // next-state prediction
  // ---------------------------------------------------------------------

  function automatic logic word_char_p(logic [7:0] c);
    return (c >= 8'h30 && c <= 8'h39) || (c >= 8'h41 && c <= 8'h5A) ||
           (c >= 8'h61 && c <= 8'h7A);
  endfunction

  function automatic logic escapable_p(logic [7:0] c);
    return c == CH_BSLASH || c == CH_HASH || c == CH_PERCENT ||
           c == CH_LBRACE || c == CH_RBRACE;
  endfunction

  // one character through the tracker; an error leaves the state untouched
  function automatic trk_t scan_next(trk_t t, logic [7:0] c, logic [1:0] n_in);
    trk_t       r;
    state_t     s;
    logic [1:0] n;
    logic       done;
    r = t;
    n = (n_in == 2'd0) ? 2'd1 : n_in;   // zero args behaves as one
    done = 1'b0;
    s = t.st;
    if (t.err != ERR_NONE) begin
      done = 1'b1;                      // sticky error: everything ignored
    end else if (s == ST_AFTER) begin
      if (c == CH_SPACE || c == CH_TAB) begin
        done = 1'b1;                    // skip leading blanks
      end else begin
        s = t.saved;                    // reprocess in the saved state
        r.st = s;
      end
    end
    if (!done && c == CH_PERCENT && s != ST_ESC && s != ST_A1E && s != ST_A2E &&
        s != ST_A3E && s != ST_COMMENT) begin
      r.saved = s;
      r.st = ST_COMMENT;
      done = 1'b1;
    end
    if (!done) begin
      case (s)
        ST_PLAIN, ST_BADESC, ST_MEND: begin
          r.st = (c == CH_BSLASH) ? ST_ESC : ST_PLAIN;
        end
        ST_ESC: begin
          if (word_char_p(c)) r.st = ST_MACRO;
          else if (escapable_p(c)) r.st = ST_PLAIN;
          else r.st = ST_BADESC;
        end
        ST_COMMENT: begin
          if (c == CH_NL) r.st = ST_AFTER;
        end
        ST_MACRO: begin
          if (c == CH_LBRACE) begin
            if (&t.depth) begin
              r.err = ERR_OVERFLOW;
            end else begin
              r.depth = t.depth + 1'b1;
              r.st = ST_A1B;
            end
          end else if (!word_char_p(c)) begin
            r.err = ERR_BAD_MACRO;
          end
        end
        ST_A1, ST_A2, ST_A3: begin
          if (c == CH_BSLASH) begin
            r.st = state_t'(s + 5'd1);
          end else if (c == CH_LBRACE) begin
            if (&t.depth) r.err = ERR_OVERFLOW;
            else r.depth = t.depth + 1'b1;
          end else if (c == CH_RBRACE) begin
            if (t.depth != '0) r.depth = t.depth - 1'b1;
            if (r.depth == '0) begin
              // balanced: move on to the next argument or end the macro
              if (n == 2'd1) r.st = ST_MEND;
              else if (n == 2'd2) r.st = (s == ST_A1) ? ST_A1END : ST_MEND;
              else if (s == ST_A1) r.st = ST_A1END;
              else if (s == ST_A2) r.st = ST_A2END;
              else r.st = ST_MEND;
            end
          end
        end
        ST_A1E, ST_A2E, ST_A3E: begin
          r.st = state_t'(s - 5'd1);
        end
        ST_A1B, ST_A2B, ST_A3B: begin
          if (c == CH_BSLASH) begin
            r.st = state_t'(s + 5'd2);
          end else if (c == CH_LBRACE) begin
            if (&t.depth) begin
              r.err = ERR_OVERFLOW;
            end else begin
              r.depth = t.depth + 1'b1;
              r.st = state_t'(s + 5'd1);
            end
          end else if (c == CH_RBRACE) begin
            if (t.depth != '0) r.depth = t.depth - 1'b1;
            if (s == ST_A1B) r.st = (n == 2'd1) ? ST_MEND : ST_A1END;
            else if (s == ST_A2B) r.st = (n == 2'd2) ? ST_MEND : ST_A2END;
            else r.st = ST_MEND;
          end else begin
            r.st = state_t'(s + 5'd1);
          end
        end
        ST_A1END, ST_A2END: begin
          if ((s == ST_A1END && n == 2'd1) || (s == ST_A2END && n == 2'd2)) begin
            r.st = ST_MEND;
          end else if (c != CH_LBRACE) begin
            r.err = ERR_NO_BRACE;
          end else if (&t.depth) begin
            r.err = ERR_OVERFLOW;
          end else begin
            r.depth = t.depth + 1'b1;
            r.st = state_t'(s + 5'd1);
          end
        end
        default: r.st = ST_PLAIN;
      endcase
    end
    return r;
  endfunction

  // ---------------------------------------------------------------------
  // character generation, biased by where the tracker currently is
  // ---------------------------------------------------------------------

  function automatic logic [7:0] any_byte();
    return 8'($urandom_range(0, 255));
  endfunction

  function automatic logic [7:0] text_char();
    return ($urandom_range(0, 9) < 7) ? 8'($urandom_range(32, 126)) : any_byte();
  endfunction

  function automatic logic [7:0] name_char();
    int i;
    i = $urandom_range(0, 61);
    if (i < 10) return 8'(8'h30 + i);
    if (i < 36) return 8'(8'h41 + i - 10);
    return 8'(8'h61 + i - 36);
  endfunction

  function automatic logic [7:0] esc_char();
    case ($urandom_range(0, 4))
      0: return CH_BSLASH;
      1: return CH_HASH;
      2: return CH_PERCENT;
      3: return CH_LBRACE;
      default: return CH_RBRACE;
    endcase
  endfunction

  function automatic logic [7:0] pick_char(trk_t t);
    state_t b;
    int     r;
    b = t.st;
    r = $urandom_range(0, 99);
    if (b == ST_AFTER) begin
      if (r < 40) return (r < 25) ? CH_SPACE : CH_TAB;
      b = t.saved;
      r = $urandom_range(0, 99);
    end
    case (b)
      ST_ESC: begin
        if (r < 65) return name_char();
        if (r < 85) return esc_char();
        return any_byte();
      end
      ST_MACRO: begin
        if (r < 45) return name_char();
        if (r < 85) return CH_LBRACE;
        if (r < 92) return CH_PERCENT;
        return any_byte();
      end
      ST_COMMENT: begin
        if (r < 30) return CH_NL;
        if (r < 40) return CH_PERCENT;
        return any_byte();
      end
      ST_A1, ST_A2, ST_A3, ST_A1B, ST_A2B, ST_A3B: begin
        if (r < 20) return CH_RBRACE;
        if (r < 30) return CH_LBRACE;
        if (r < 42) return CH_BSLASH;
        if (r < 47) return CH_PERCENT;
        return text_char();
      end
      ST_A1E, ST_A2E, ST_A3E: begin
        if (r < 40) return esc_char();
        return any_byte();
      end
      ST_A1END, ST_A2END: begin
        if (r < 85) return CH_LBRACE;
        if (r < 92) return CH_PERCENT;
        return any_byte();
      end
      default: begin
        if (r < 30) return CH_BSLASH;
        if (r < 38) return CH_PERCENT;
        if (r < 45) return CH_NL;
        return text_char();
      end
    endcase
  endfunction

  // queue a character and advance the generator's view of the tracker
  task automatic push_char(logic [7:0] c, logic [1:0] n, logic hold);
    word_t w;
    w.ch = c;
    w.nargs = n;
    w.hold = hold;
    char_q.push_back(w);
    gen_trk = scan_next(gen_trk, c, n);
    // a fresh escape may open a macro: choose its argument count
    if (gen_trk.st == ST_ESC) gen_nargs = 2'($urandom_range(1, 3));
  endtask

  // ---------------------------------------------------------------------
  // driver: one character word per handshake, with random idle bursts
  // ---------------------------------------------------------------------

  always @(posedge clk) begin : driver
    word_t w;
    int    phase;
    if (rst) begin
      s_tvalid <= 1'b0;
      s_tdata  <= '0;
      tx_gap   <= 0;
    end else if (!s_tvalid || s_tready) begin
      if (s_tvalid) n_acc <= n_acc + 1;
      phase = (n_acc / 48) % 3;   // none, light, heavy idling
      if (tx_gap > 0) begin
        tx_gap   <= tx_gap - 1;
        s_tvalid <= 1'b0;
      end else if (char_q.size() == 0) begin
        s_tvalid <= 1'b0;
      end else if (char_q[0].hold && (s_tvalid || n_acc != n_got)) begin
        // pause until every predicted result has been seen
        s_tvalid <= 1'b0;
      end else begin
        w = char_q.pop_front();
        s_tdata  <= {{(IN_TDATA_W - 10){1'b0}}, w.nargs, w.ch};
        s_tvalid <= 1'b1;
        if (!rx_long && n_acc < total_items - CALM_TAIL && phase != 0 &&
            $urandom_range(0, 7) < ((phase == 1) ? 1 : 3))
          tx_gap <= $urandom_range(1, 16);
      end
    end
  end

  // ---------------------------------------------------------------------
  // result side backpressure: random bursts plus one long hold-off
  // ---------------------------------------------------------------------

  always @(posedge clk) begin : receiver
    int phase;
    if (rst) begin
      m_tready <= 1'b0;
      rx_gap   <= 0;
    end else if (rx_gap > 0) begin
      rx_gap   <= rx_gap - 1;
      m_tready <= 1'b0;
    end else if (!long_done && n_got >= 120) begin
      // long stall so the pipeline fills and the input backs up
      rx_gap    <= 64;
      rx_long   <= 1'b1;
      long_done <= 1'b1;
      m_tready  <= 1'b0;
    end else begin
      rx_long <= 1'b0;
      phase = (n_got / 40) % 3;
      if (n_got < total_items - CALM_TAIL && phase != 0 &&
          $urandom_range(0, 7) < ((phase == 1) ? 1 : 3)) begin
        rx_gap   <= $urandom_range(0, 15);
        m_tready <= 1'b0;
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  // ---------------------------------------------------------------------
  // monitor: predict on every accepted character, check every result
  // ---------------------------------------------------------------------

  always @(posedge clk) begin : monitor
    syntax_t want;
    if (!rst) begin
      if (s_tvalid && s_tready) begin
        tracker_now = scan_next(tracker_now, s_tdata[7:0], s_tdata[9:8]);
        if (int'(tracker_now.depth) > deepest) deepest = int'(tracker_now.depth);
        want.st  = tracker_now.st;
        want.err = tracker_now.err;
        syntax_q.push_back(want);
      end
      if (m_tvalid && m_tready) begin
        n_got <= n_got + 1;
        if (syntax_q.size() == 0) begin
          mismatches++;
          $display("%0t: result word with nothing expected, got state %0d err %0d",
                   $time, m_tdata[4:0], m_tdata[6:5]);
        end else begin
          want = syntax_q.pop_front();
          if (m_tdata[4:0] !== want.st) begin
            mismatches++;
            $display("%0t: syntax_state expected %0d, actual %0d",
                     $time, want.st, m_tdata[4:0]);
          end
          if (m_tdata[6:5] !== want.err) begin
            mismatches++;
            $display("%0t: error_code expected %0d, actual %0d",
                     $time, want.err, m_tdata[6:5]);
          end
        end
      end
    end
  end

  // ---------------------------------------------------------------------
  // stimulus and end of run
  // ---------------------------------------------------------------------

  initial begin : stimulus
    logic [7:0] c;
    logic [1:0] n;
    trk_t       nxt;
    int         kind;
    int         n_rand;
    gen_trk     = '0;   // plain text, depth zero, no error
    tracker_now = '0;

    // the closing error is picked up front; nesting to overflow takes about
    // one word per depth step, so the random part is shortened to match
    kind   = $urandom_range(1, 3);
    n_rand = N_RANDOM - ((kind == 3) ? (1 << DEPTH_W) : 0);

    // directed: byte extremes, bad escape, escaped percent, comments and
    // blanks, percent right after a comment, escapes and nesting in args
    push_char(8'h00, 2'd0, 1'b0);       push_char(8'hFF, 2'd3, 1'b0);
    push_char(CH_BSLASH, 2'd3, 1'b0);   push_char(8'hFF, 2'd3, 1'b0);
    push_char(CH_BSLASH, 2'd3, 1'b0);   push_char(CH_PERCENT, 2'd3, 1'b0);
    push_char(CH_BSLASH, 2'd3, 1'b0);   push_char("Z", 2'd3, 1'b0);
    push_char(CH_PERCENT, 2'd3, 1'b0);  push_char(CH_PERCENT, 2'd3, 1'b0);
    push_char(CH_NL, 2'd3, 1'b0);       push_char(CH_TAB, 2'd3, 1'b0);
    push_char(CH_SPACE, 2'd3, 1'b0);    push_char(CH_PERCENT, 2'd3, 1'b0);
    push_char(CH_NL, 2'd3, 1'b0);       push_char(CH_LBRACE, 2'd3, 1'b0);
    push_char(CH_BSLASH, 2'd3, 1'b0);   push_char(CH_PERCENT, 2'd3, 1'b0);
    push_char(CH_LBRACE, 2'd3, 1'b0);   push_char(CH_RBRACE, 2'd3, 1'b0);
    push_char(CH_RBRACE, 2'd3, 1'b0);   push_char(CH_LBRACE, 2'd3, 1'b0);
    push_char(CH_RBRACE, 2'd3, 1'b0);   push_char(CH_LBRACE, 2'd3, 1'b0);
    push_char("q", 2'd3, 1'b0);         push_char(CH_RBRACE, 2'd3, 1'b0);
    push_char("0", 2'd0, 1'b0);

    // random macro text; any error is sticky, so errors are kept for the end
    for (int k = 0; k < n_rand; k++) begin
      do begin
        c = pick_char(gen_trk);
        n = ($urandom_range(0, 11) == 0) ? 2'($urandom_range(0, 3)) : gen_nargs;
        nxt = scan_next(gen_trk, c, n);
      end while (nxt.err != ERR_NONE);
      push_char(c, n, k == 0 || k == (n_rand * 2) / 3);
    end

    // steer into a macro name, then provoke one of the three errors
    while (gen_trk.st != ST_MACRO) begin
      case (gen_trk.st)
        ST_PLAIN, ST_MEND, ST_BADESC: c = CH_BSLASH;
        ST_ESC:                       c = "m";
        ST_COMMENT:                   c = CH_NL;
        ST_A1E, ST_A2E, ST_A3E:       c = "a";
        ST_A1, ST_A2, ST_A3,
        ST_A1B, ST_A2B, ST_A3B:       c = CH_RBRACE;
        default:                      c = CH_LBRACE;
      endcase
      push_char(c, 2'd1, 1'b0);
    end
    case (kind)
      1: push_char("!", 2'd1, 1'b0);               // bad macro name character
      2: begin                                     // second argument missing
        push_char(CH_LBRACE, 2'd2, 1'b0);
        push_char("x", 2'd2, 1'b0);
        push_char(CH_RBRACE, 2'd2, 1'b0);
        push_char("z", 2'd2, 1'b0);
      end
      default: begin                               // nest until depth overflows
        while (gen_trk.err == ERR_NONE) push_char(CH_LBRACE, 2'd3, 1'b0);
      end
    endcase
    // the error must hold against whatever follows
    for (int k = 0; k < 6; k++) push_char(any_byte(), 2'($urandom_range(0, 3)), 1'b0);
    total_items = char_q.size();

    repeat (5) @(posedge clk);
    rst <= 1'b0;

    while (char_q.size() != 0 || s_tvalid || n_acc != n_got) @(posedge clk);
    repeat (8) @(posedge clk);
    if (syntax_q.size() != 0) begin
      mismatches++;
      $display("%0t: %0d expected result words never arrived", $time, syntax_q.size());
    end

    $display("covered %0d characters, brace nesting up to %0d, both stall kinds",
             n_acc, deepest);
    $display("stream closed on sticky error code %0d, %0d mismatches",
             tracker_now.err, mismatches);
    if (mismatches == 0) begin
      $display("** macro_syntax_state_tracker: PASSED **");
    end else begin
      $display("** macro_syntax_state_tracker: FAILED **");
    end
    $finish;
  end

  // hard stop in case the handshake hangs
  initial begin : watchdog
    #400000;
    $display("%0t: timeout, %0d sent, %0d received", $time, n_acc, n_got);
    $display("** macro_syntax_state_tracker: FAILED **");
    $finish;
  end

endmodule
